/* design/crc8fp_pkg.sv */
// ----------------------------------------------------------------------------
// crc8fp_pkg
// Shared types, codes and the CRC-8 byte update for the sync frame parser.
// ----------------------------------------------------------------------------
package crc8fp_pkg;

  localparam logic [7:0] SyncFirstRst  = 8'hAA;
  localparam logic [7:0] SyncSecondRst = 8'h55;
  localparam logic [7:0] CrcPoly       = 8'h8C;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [0:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_MORE  = 2'd0,
    ST_LOST  = 2'd1,
    ST_READY = 2'd2,
    ST_DATA  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_HEADER  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CRC     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CMD_MORE  = 2'd0,
    CMD_LOST  = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_kind_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_DATA = 1'b1
  } back_state_e;

  // one classified word handed from the parser to the replay side
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  msg_id;
    logic [5:0]  len;
  } cmd_t;

  // one result word
  typedef struct packed {
    status_e     status;
    logic [7:0]  msg_id;
    logic [5:0]  len;
    logic [7:0]  data;
    logic        last;
  } res_t;

  // CRC-8/Maxim, reflected, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/crc8fp_ram.sv */
// ----------------------------------------------------------------------------
// crc8fp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc8fp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/crc8fp_queue.sv */
// ----------------------------------------------------------------------------
// crc8fp_queue
// Short first-word-fall-through queue of parser commands.
// ----------------------------------------------------------------------------
module crc8fp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crc8fp_pkg::cmd_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output crc8fp_pkg::cmd_t  head_o,
  output logic              empty_o
);
  import crc8fp_pkg::*;

  cmd_t              entry_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCntW'(QDepth));

endmodule

/* design/crc8fp_front.sv */
// ----------------------------------------------------------------------------
// crc8fp_front
// Parser: hunt for sync, take header, payload and CRC; push one command per word.
// ----------------------------------------------------------------------------
module crc8fp_front #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        sync_first_i,
  input  logic [7:0]        sync_second_i,
  input  logic              rx_valid_i,
  output logic              rx_stall_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              q_full_i,
  output logic              push_o,
  output crc8fp_pkg::cmd_t  push_data_o,
  output logic              ram_we_o,
  output logic [AW-1:0]     ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  input  logic              replay_done_i,
  output logic              frame_pend_o
);
  import crc8fp_pkg::*;

  phase_e      phase_q, phase_d;
  logic        hdr_step_q, hdr_step_d;
  logic [7:0]  id_q, id_d;
  logic [5:0]  len_q, len_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic        pend_q, pend_d;
  logic        accept;
  logic [7:0]  crc_next;
  logic [5:0]  cnt_inc;

  // hold off every word while the queue is full, and payload and CRC words while the previous frame still replays
  assign rx_stall_o = q_full_i ||
                      (pend_q && ((phase_q == PH_PAYLOAD) || (phase_q == PH_CRC)));
  assign accept     = rx_valid_i && !rx_stall_o;
  assign crc_next   = crc8_byte(crc_q, rx_byte_i);
  assign cnt_inc    = cnt_q + 6'd1;

  always_comb begin
    phase_d     = phase_q;
    hdr_step_d  = hdr_step_q;
    id_d        = id_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    crc_d       = crc_q;
    pend_d      = pend_q && !replay_done_i;
    push_o      = accept;
    push_data_o = '{kind: CMD_MORE, msg_id: 8'd0, len: 6'd0};
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q[AW-1:0];
    ram_wdata_o = rx_byte_i;
    if (accept) begin
      case (phase_q)
        PH_SYNC1: begin
          if (rx_byte_i == sync_first_i) begin
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (rx_byte_i == sync_second_i) begin
            phase_d    = PH_HEADER;
            hdr_step_d = 1'b0;
            cnt_d      = 6'd0;
            crc_d      = 8'd0;
          end else begin
            push_data_o.kind = CMD_LOST;
            phase_d = (rx_byte_i == sync_first_i) ? PH_SYNC2 : PH_SYNC1;
          end
        end
        PH_HEADER: begin
          crc_d = crc_next;
          if (!hdr_step_q) begin
            id_d       = rx_byte_i;
            hdr_step_d = 1'b1;
          end else begin
            hdr_step_d = 1'b0;
            cnt_d      = 6'd0;
            if (rx_byte_i > 8'(MAX_PAYLOAD)) begin
              push_data_o.kind = CMD_LOST;
              phase_d = PH_SYNC1;
              id_d    = 8'd0;
              len_d   = 6'd0;
              crc_d   = 8'd0;
            end else begin
              len_d   = rx_byte_i[5:0];
              phase_d = (rx_byte_i[5:0] == 6'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d    = crc_next;
          ram_we_o = 1'b1;
          cnt_d    = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          if (rx_byte_i != crc_q) begin
            push_data_o.kind = CMD_LOST;
          end else begin
            push_data_o = '{kind: CMD_FRAME, msg_id: id_q, len: len_q};
            pend_d      = 1'b1;
          end
          phase_d    = PH_SYNC1;
          hdr_step_d = 1'b0;
          id_d       = 8'd0;
          len_d      = 6'd0;
          cnt_d      = 6'd0;
          crc_d      = 8'd0;
        end
        default: begin
          push_data_o.kind = CMD_LOST;
          phase_d    = PH_SYNC1;
          hdr_step_d = 1'b0;
          id_d       = 8'd0;
          len_d      = 6'd0;
          cnt_d      = 6'd0;
          crc_d      = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SYNC1;
      hdr_step_q <= 1'b0;
      id_q       <= 8'd0;
      len_q      <= 6'd0;
      cnt_q      <= 6'd0;
      crc_q      <= 8'd0;
      pend_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      hdr_step_q <= hdr_step_d;
      id_q       <= id_d;
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      pend_q     <= pend_d;
    end
  end

  assign frame_pend_o = pend_q;

endmodule

/* design/crc8fp_back.sv */
// ----------------------------------------------------------------------------
// crc8fp_back
// Replay: turn commands into result words, reading frame payload from the RAM.
// ----------------------------------------------------------------------------
module crc8fp_back #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crc8fp_pkg::cmd_t  head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              ram_re_o,
  output logic [AW-1:0]     ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              replay_done_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crc8fp_pkg::res_t  out_o
);
  import crc8fp_pkg::*;

  back_state_e  state_q, state_d;
  logic [5:0]   idx_q, idx_d;
  logic [7:0]   id_q, id_d;
  logic [5:0]   len_q, len_d;
  res_t         out_q, out_d;
  logic         out_valid_q, out_valid_d;
  logic         load_ok;
  logic [5:0]   idx_inc;
  logic         is_last;

  assign load_ok = !out_valid_q || !out_stall_i;
  assign idx_inc = idx_q + 6'd1;
  assign is_last = (idx_inc == len_q);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    id_d          = id_q;
    len_d         = len_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    pop_o         = 1'b0;
    ram_re_o      = 1'b0;
    ram_raddr_o   = idx_q[AW-1:0];
    replay_done_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && load_ok) begin
          pop_o       = 1'b1;
          out_valid_d = 1'b1;
          case (head_i.kind)
            CMD_MORE: begin
              out_d = '{status: ST_MORE, msg_id: 8'd0, len: 6'd0, data: 8'd0, last: 1'b1};
            end
            CMD_FRAME: begin
              out_d = '{status: ST_READY, msg_id: head_i.msg_id, len: head_i.len,
                        data: 8'd0, last: (head_i.len == 6'd0)};
              id_d  = head_i.msg_id;
              len_d = head_i.len;
              if (head_i.len == 6'd0) begin
                replay_done_o = 1'b1;
              end else begin
                // fetch the first payload word alongside the header
                ram_re_o    = 1'b1;
                ram_raddr_o = '0;
                idx_d       = 6'd0;
                state_d     = BK_DATA;
              end
            end
            default: begin
              out_d = '{status: ST_LOST, msg_id: 8'd0, len: 6'd0, data: 8'd0, last: 1'b1};
            end
          endcase
        end
      end
      BK_DATA: begin
        // read data holds while the output is stalled
        if (load_ok) begin
          out_valid_d = 1'b1;
          out_d = '{status: ST_DATA, msg_id: id_q, len: len_q, data: ram_rdata_i,
                    last: is_last};
          if (is_last) begin
            replay_done_o = 1'b1;
            state_d       = BK_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_inc[AW-1:0];
            idx_d       = idx_inc;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= 6'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    len_q <= len_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* design/sync_crc8_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// sync_crc8_frame_parser_core
// Two-sync-byte framed packet parser with CRC-8/Maxim check and payload replay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one received word (rx_byte_i) per handshake, rx_valid_i /
//   rx_stall_o. Output channel: result words (status, msg_id, payload_len,
//   data_byte, last) on out_valid_o / out_stall_i.
//   Every accepted word gives one result (need_more or sync_lost), except a
//   CRC word that matches: it gives a frame_ready header followed by one
//   result per payload word, the final one flagged by last_o.
//   The first result of a word passes the command queue, written at the edge
//   that accepts the word, and then the output register. The parser takes
//   one word per cycle while rx_stall_o is low; a frame of N payload words
//   replays as a frame_ready header and N data results, one result per cycle
//   while out_stall_i is low, read from the single payload RAM read port.
//   Payload and CRC words of the next frame wait (rx_stall_o high) until the
//   replay of the previous frame has finished; sync and header words pass.
//   rx_stall_o also rises when the two-entry command queue is full, which
//   happens when the receiver holds out_stall_i high or a replay keeps the
//   back side busy while further words arrive.
//   Reset clears the parser to the sync hunt, empties the queue and drops
//   any pending result; sync values return to 0xAA and 0x55. No RAM clear.
//   Configuration: cfg_we_i with cfg_idx_i (0 sync_first, 1 sync_second), to be
//   written by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sync_crc8_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  msg_id_o,
  output logic [5:0]  payload_len_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import crc8fp_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]     sync_first_q;
  logic [7:0]     sync_second_q;
  logic           q_push, q_full, q_pop, q_empty;
  cmd_t           q_in, q_head;
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]     ram_wdata, ram_rdata;
  logic           replay_done, frame_pend;
  res_t           res;

  // sync value registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_wdata_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // front: classify each word, store payload
  crc8fp_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .push_data_o   (q_in),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .replay_done_i (replay_done),
    .frame_pend_o  (frame_pend)
  );

  crc8fp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  // payload store, one frame deep
  crc8fp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // back: emit results, replay payload
  crc8fp_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_empty_i     (q_empty),
    .pop_o         (q_pop),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .replay_done_o (replay_done),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_o         (res)
  );

  assign status_o      = res.status;
  assign msg_id_o      = res.msg_id;
  assign payload_len_o = res.len;
  assign data_byte_o   = res.data;
  assign last_o        = res.last;

  // no push into a full queue
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("command pushed into full queue");

  // no pop from an empty queue
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("command popped from empty queue");

  // payload store is never overwritten while a frame is replaying
  a_ram_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !frame_pend) else $error("payload written during replay");

  // replay end only for a frame the front has handed over
  a_done_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    replay_done |-> frame_pend) else $error("replay done without pending frame");

endmodule

/* tb/sv/tb_sync_crc8_frame_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_sync_crc8_frame_parser_core
// Self-checking bench for the sync-byte frame parser: a byte-level parser
// model predicts every result word, and a monitor compares them in order.
// A short stimulus table comes first, then random frames under several sync
// settings, idle patterns, and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sync_crc8_frame_parser_core;
  import crc8fp_pkg::*;

  localparam int          MaxPayload  = 32;
  localparam logic [7:0]  PolyRefl    = 8'h8C;
  localparam int          LimitCycles = 400000;
  localparam int          HoldCycles  = 400;
  localparam int          MaxReports  = 10;

  // idle patterns of the two channels
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_TX,
    IDLE_RX,
    IDLE_BOTH
  } idle_mode_e;

  // how a table row fills its byte: as written, or from the running CRC
  typedef enum logic [1:0] {
    FILL_NONE,
    FILL_CRC_OK,
    FILL_CRC_BAD
  } crc_fill_e;

  typedef struct {
    logic [7:0] val;
    crc_fill_e  fill;
    bit         typed;
    status_e    st;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [0:0] cfg_idx     = CFG_SYNC_FIRST;
  logic [7:0] cfg_wdata   = 8'h00;
  logic       rx_valid    = 1'b0;
  logic [7:0] rx_byte     = 8'h00;
  logic       out_stall   = 1'b0;
  logic       rx_stall;
  logic       out_valid;
  logic [1:0] status;
  logic [7:0] msg_id;
  logic [5:0] payload_len;
  logic [7:0] data_byte;
  logic       last;

  idle_mode_e idle_mode = IDLE_NONE;
  bit         hold_req  = 1'b0;
  bit         hold_on   = 1'b0;
  int         mism_cnt  = 0;
  int         cyc_cnt   = 0;
  int         items     = 0;

  // result words the parser still owes, oldest first
  res_t parsed_words[$];
  res_t step_words[$];
  res_t mon_want;

  // parser model state
  logic [7:0] sync_a;
  logic [7:0] sync_b;
  phase_e     cur_phase;
  bit         hdr_second;
  logic [7:0] frm_id;
  logic [5:0] frm_len;
  logic [5:0] pay_cnt;
  logic [7:0] crc_acc;
  logic [7:0] pay_mem [MaxPayload];

  // Directed words under the reset sync values 0xAA / 0x55.
  row_t dir_rows [27] = '{
    '{8'h00, FILL_NONE,    1'b1, ST_MORE},   // hunt, no sync
    '{8'hFF, FILL_NONE,    1'b1, ST_MORE},
    '{8'hAA, FILL_NONE,    1'b1, ST_MORE},   // first sync
    '{8'hAA, FILL_NONE,    1'b1, ST_LOST},   // repeated first sync keeps the hunt armed
    '{8'h55, FILL_NONE,    1'b1, ST_MORE},   // second sync
    '{8'h00, FILL_NONE,    1'b1, ST_MORE},   // id
    '{8'h00, FILL_NONE,    1'b1, ST_MORE},   // zero length
    '{8'h00, FILL_CRC_OK,  1'b1, ST_READY},  // CRC of all zeros is zero
    '{8'hAA, FILL_NONE,    1'b1, ST_MORE},
    '{8'h13, FILL_NONE,    1'b1, ST_LOST},   // neither sync: back to the hunt
    '{8'hAA, FILL_NONE,    1'b1, ST_MORE},
    '{8'h55, FILL_NONE,    1'b1, ST_MORE},
    '{8'hFF, FILL_NONE,    1'b1, ST_MORE},
    '{8'h21, FILL_NONE,    1'b1, ST_LOST},   // length one above the maximum
    '{8'hAA, FILL_NONE,    1'b1, ST_MORE},
    '{8'h55, FILL_NONE,    1'b1, ST_MORE},
    '{8'h5A, FILL_NONE,    1'b1, ST_MORE},
    '{8'h01, FILL_NONE,    1'b1, ST_MORE},
    '{8'hFF, FILL_NONE,    1'b1, ST_MORE},
    '{8'h00, FILL_CRC_BAD, 1'b1, ST_LOST},   // bad CRC
    '{8'hAA, FILL_NONE,    1'b1, ST_MORE},
    '{8'h55, FILL_NONE,    1'b1, ST_MORE},
    '{8'h80, FILL_NONE,    1'b1, ST_MORE},
    '{8'h02, FILL_NONE,    1'b1, ST_MORE},
    '{8'h01, FILL_NONE,    1'b1, ST_MORE},
    '{8'hFE, FILL_NONE,    1'b1, ST_MORE},
    '{8'h00, FILL_CRC_OK,  1'b0, ST_READY}   // header plus two payload words
  };

  sync_crc8_frame_parser_core #(
    .MAX_PAYLOAD  (MaxPayload)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .rx_valid_i    (rx_valid),
    .rx_stall_o    (rx_stall),
    .rx_byte_i     (rx_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .msg_id_o      (msg_id),
    .payload_len_o (payload_len),
    .data_byte_o   (data_byte),
    .last_o        (last)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Bit-serial CRC-8/Maxim, LSB first.
  function automatic logic [7:0] crc_maxim(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) begin
        c = c ^ PolyRefl;
      end
    end
    return c;
  endfunction

  task automatic restart_hunt();
    cur_phase  = PH_SYNC1;
    hdr_second = 1'b0;
    frm_id     = 8'h00;
    frm_len    = 6'd0;
    pay_cnt    = 6'd0;
    crc_acc    = 8'h00;
  endtask

  // Advance the parser model by one accepted word; leave its results in step_words.
  task automatic parse_byte(input logic [7:0] b);
    res_t r;
    step_words.delete();
    r = '{status: ST_MORE, msg_id: 8'h00, len: 6'd0, data: 8'h00, last: 1'b1};
    case (cur_phase)
      PH_SYNC1: begin
        if (b == sync_a) begin
          cur_phase = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        // the second sync value wins when both match
        if (b == sync_b) begin
          cur_phase  = PH_HEADER;
          hdr_second = 1'b0;
          pay_cnt    = 6'd0;
          crc_acc    = 8'h00;
        end else begin
          cur_phase = (b == sync_a) ? PH_SYNC2 : PH_SYNC1;
          r.status  = ST_LOST;
        end
      end
      PH_HEADER: begin
        crc_acc = crc_maxim(crc_acc, b);
        if (!hdr_second) begin
          frm_id     = b;
          hdr_second = 1'b1;
        end else begin
          hdr_second = 1'b0;
          pay_cnt    = 6'd0;
          if (b > MaxPayload) begin
            restart_hunt();
            r.status = ST_LOST;
          end else begin
            frm_len   = b[5:0];
            cur_phase = (frm_len == 0) ? PH_CRC : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_acc = crc_maxim(crc_acc, b);
        pay_mem[int'(pay_cnt)] = b;
        pay_cnt = pay_cnt + 6'd1;
        if (pay_cnt >= frm_len) begin
          cur_phase = PH_CRC;
        end
      end
      PH_CRC: begin
        if (b != crc_acc) begin
          restart_hunt();
          r.status = ST_LOST;
        end else begin
          r = '{status: ST_READY, msg_id: frm_id, len: frm_len, data: 8'h00,
                last: (frm_len == 0)};
          step_words.push_back(r);
          for (int i = 0; i < int'(frm_len); i++) begin
            r = '{status: ST_DATA, msg_id: frm_id, len: frm_len, data: pay_mem[i],
                  last: (i + 1 == int'(frm_len))};
            step_words.push_back(r);
          end
          restart_hunt();
          return;
        end
      end
      default: begin
        restart_hunt();
        r.status = ST_LOST;
      end
    endcase
    step_words.push_back(r);
  endtask

  // Offer one word, hold it until accepted, then record what it must produce.
  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input status_e st = ST_MORE);
    int gap;
    int pct;
    gap = 0;
    pct = (idle_mode == IDLE_TX) ? 80 : (idle_mode == IDLE_BOTH) ? 24 : 0;
    while (gap < 40 && $urandom_range(99) < pct) begin
      gap++;
    end
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (rx_stall);
    parse_byte(b);
    if (typed) begin
      parsed_words.push_back('{status: st, msg_id: 8'h00, len: 6'd0, data: 8'h00,
                               last: 1'b1});
    end else begin
      foreach (step_words[i]) begin
        parsed_words.push_back(step_words[i]);
      end
    end
    items++;
  endtask

  // One frame with random content; sometimes noisy, broken or oversize.
  task automatic send_frame(input int force_len);
    int len;
    int r;
    if ($urandom_range(99) < 20) begin
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
    end
    push_byte(sync_a);
    if ($urandom_range(99) < 15) begin
      push_byte(sync_a);
    end
    if ($urandom_range(99) < 8) begin
      push_byte(8'($urandom_range(255)));
    end else begin
      push_byte(sync_b);
    end
    push_byte(8'($urandom_range(255)));
    r = $urandom_range(99);
    if (force_len >= 0) begin
      len = force_len;
    end else if (r < 55) begin
      len = $urandom_range(6);
    end else if (r < 80) begin
      len = $urandom_range(31, 7);
    end else if (r < 88) begin
      len = MaxPayload;
    end else begin
      len = $urandom_range(255, MaxPayload + 1);
    end
    push_byte(8'(len));
    if (len <= MaxPayload) begin
      repeat (len) push_byte(8'($urandom_range(255)));
      // the model's running CRC is current: every earlier word is accepted
      if ($urandom_range(99) < 85) begin
        push_byte(crc_acc);
      end else begin
        push_byte(crc_acc ^ 8'($urandom_range(255, 1)));
      end
    end
  endtask

  // Drop valid and wait until every owed result word has come out.
  task automatic drain();
    rx_valid <= 1'b0;
    while (parsed_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_SYNC_FIRST) begin
      sync_a = v;
    end else begin
      sync_b = v;
    end
  endtask

  task automatic run_frames(input int n_items);
    int stop_at;
    stop_at = items + n_items;
    while (items < stop_at) begin
      send_frame(-1);
    end
  endtask

  // Receiver stall: random per idle mode, forced high during the hold-off.
  always @(posedge clk_i) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RX) begin
      out_stall <= ($urandom_range(99) < 80);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(99) < 24);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Long hold-off of the output, counted here while the sender keeps offering words.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // Compare every accepted result word with the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (parsed_words.size() == 0) begin
        mism_cnt = mism_cnt + 1;
        if (mism_cnt <= MaxReports) begin
          $display("unexpected result word: status %0d id %02h len %0d data %02h last %0d",
                   status, msg_id, payload_len, data_byte, last);
        end
      end else begin
        mon_want = parsed_words.pop_front();
        if (status !== mon_want.status || msg_id !== mon_want.msg_id ||
            payload_len !== mon_want.len || data_byte !== mon_want.data ||
            last !== mon_want.last) begin
          mism_cnt = mism_cnt + 1;
          if (mism_cnt <= MaxReports) begin
            $display("mismatch: expected status %0d id %02h len %0d data %02h last %0d",
                     mon_want.status, mon_want.msg_id, mon_want.len, mon_want.data,
                     mon_want.last);
            $display("          got      status %0d id %02h len %0d data %02h last %0d",
                     status, msg_id, payload_len, data_byte, last);
          end
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= LimitCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] b;
    sync_a = SyncFirstRst;
    sync_b = SyncSecondRst;
    restart_hunt();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table under the reset sync values.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].fill)
        FILL_CRC_OK:  b = crc_acc;
        FILL_CRC_BAD: b = crc_acc ^ 8'h01;
        default:      b = dir_rows[i].val;
      endcase
      push_byte(b, dir_rows[i].typed, dir_rows[i].st);
    end
    drain();

    // Reset sync values written back; start with a frame of maximum length.
    write_cfg(CFG_SYNC_FIRST, 8'hAA);
    write_cfg(CFG_SYNC_SECOND, 8'h55);
    send_frame(MaxPayload);
    run_frames(70);
    drain();

    // Extreme sync values, sender idling.
    idle_mode <= IDLE_TX;
    write_cfg(CFG_SYNC_FIRST, 8'h00);
    write_cfg(CFG_SYNC_SECOND, 8'hFF);
    run_frames(85);
    drain();

    // Swapped extremes, receiver stalling.
    idle_mode <= IDLE_RX;
    write_cfg(CFG_SYNC_FIRST, 8'hFF);
    write_cfg(CFG_SYNC_SECOND, 8'h00);
    run_frames(85);
    drain();

    // Equal sync values, both sides idling.
    idle_mode <= IDLE_BOTH;
    write_cfg(CFG_SYNC_FIRST, 8'h3C);
    write_cfg(CFG_SYNC_SECOND, 8'h3C);
    run_frames(85);
    drain();

    // Random sync values; hold the output off while frames keep coming.
    idle_mode <= IDLE_NONE;
    write_cfg(CFG_SYNC_FIRST, 8'($urandom_range(255)));
    write_cfg(CFG_SYNC_SECOND, 8'($urandom_range(255)));
    hold_req = 1'b1;
    send_frame(MaxPayload);
    run_frames(50);
    drain();
    repeat (16) @(posedge clk_i);

    if (mism_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
